FILE: hdl/ascii_integer_parser_macros.svh
// Assertion macros shared by the checker of the integer parser.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/aip_pkg.sv
// Shared types and constants of the ASCII integer parser.
// No dependencies; the files that use it refer to it by scoped names.
package aip_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned AccW     = 64;
  localparam int unsigned OffW     = 13;
  localparam int unsigned DigitW   = 6;
  localparam int unsigned RadixW   = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 6;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgRadix  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSigned = 1'b1;

  // Signed 64-bit limits.
  localparam logic [AccW-1:0] LlongMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] LlongMin = {1'b1, {(AccW-1){1'b0}}};

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PhSpace    = 6'b000001,
    PhStart    = 6'b000010,
    PhZero     = 6'b000100,
    PhHexFirst = 6'b001000,
    PhDigits   = 6'b010000,
    PhDone     = 6'b100000
  } aip_phase_e;

  // One classified character as it waits in the queue.
  typedef struct packed {
    logic [DigitW-1:0] digit;   // 0..35, 36 when not a digit
    logic              blank;
    logic              sign;
    logic              minus;
    logic              is_x;
    logic              last;
  } aip_item_t;

  // Raw outcome of a string, before sign handling.
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic [OffW-1:0] stop;
    logic            negative;
    logic            any_digit;
  } aip_raw_t;

endpackage

FILE: hdl/aip_char_if.sv
// Character channel of the integer parser: valid/ready plus one byte.
// Depends on nothing.
interface aip_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, char_code, last, input ready);
  modport sink   (input valid, char_code, last, output ready);
endinterface

FILE: hdl/aip_result_if.sv
// Result channel of the integer parser: valid/ready plus the parsed value.
// Depends on aip_pkg for field widths.
interface aip_result_if;
  logic                      valid;
  logic                      ready;
  logic [aip_pkg::AccW-1:0]  value;
  logic [aip_pkg::OffW-1:0]  end_offset;
  logic                      converted;
  logic                      range_error;

  modport source (output valid, value, end_offset, converted, range_error, input ready);
  modport sink   (input valid, value, end_offset, converted, range_error, output ready);
endinterface

FILE: hdl/ascii_integer_parser.sv
// Top level of the streaming ASCII integer parser: configuration
// registers, front end and back end. Depends on aip_pkg, aip_char_if,
// aip_result_if, aip_front and aip_back.
//
//   channel   direction  payload                                     item
//   in_ch     sink       char_code[7:0], last                        one character
//   out_ch    source     value[63:0], end_offset[12:0], converted,   one parsed string
//                        range_error
//   cfg       write      cfg_index_i[0], cfg_data_i[5:0]             register write
//
// One character per cycle is sustained unless a last character waits on full
// result registers; the back end's digit step is one combinational 64x6 multiply-add.
// A result goes from the queue through the raw result register to the output register.
// Reset is asynchronous and active low; there is no clearing pass.
// A two-entry queue and two result registers let either side stall alone.
module ascii_integer_parser #(
  parameter int unsigned MaxChars = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  aip_char_if.sink                         in_ch,
  aip_result_if.source                     out_ch,
  input  logic                             cfg_we_i,
  input  logic [aip_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [aip_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [aip_pkg::RadixW-1:0] radix_q;
  logic                       signed_q;
  logic                       q_valid, q_ready;
  aip_pkg::aip_item_t         q_item;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q  <= '0;
      signed_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        aip_pkg::CfgRadix:  radix_q  <= cfg_data_i[aip_pkg::RadixW-1:0];
        aip_pkg::CfgSigned: signed_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  aip_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_ch     (in_ch),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_ready_i (q_ready)
  );

  aip_back #(
    .MaxChars (MaxChars)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_ready_o     (q_ready),
    .radix_i       (radix_q),
    .signed_mode_i (signed_q),
    .out_ch        (out_ch)
  );

endmodule

FILE: hdl/aip_front.sv
// Front end: accepts characters, classifies them and queues them.
// Depends on aip_pkg and aip_char_if.
module aip_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  aip_char_if.sink            in_ch,
  output logic                q_valid_o,
  output aip_pkg::aip_item_t  q_item_o,
  input  logic                q_ready_i
);

  localparam int unsigned Depth = 2;
  localparam int unsigned PtrW  = 1;
  localparam int unsigned CntW  = 2;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam logic [aip_pkg::DigitW-1:0] NoDigit = 6'd36;

  aip_pkg::aip_item_t        entries_q [Depth];
  logic [PtrW-1:0]           wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]           count_q;
  aip_pkg::aip_item_t        item_cls;
  logic [7:0]                c;
  logic                      push, pop;

  assign c = in_ch.char_code;

  // Character classification.
  always_comb begin
    item_cls = '0;
    if (c >= Ch0 && c <= Ch9) begin
      item_cls.digit = 6'(c - Ch0);
    end else if (c >= ChLowA && c <= ChLowZ) begin
      item_cls.digit = 6'(c - ChLowA + 8'd10);
    end else if (c >= ChUpA && c <= ChUpZ) begin
      item_cls.digit = 6'(c - ChUpA + 8'd10);
    end else begin
      item_cls.digit = NoDigit;
    end
    item_cls.blank = (c == ChSpace) || (c >= ChTab && c <= ChCr);
    item_cls.sign  = (c == ChPlus) || (c == ChMinus);
    item_cls.minus = (c == ChMinus);
    item_cls.is_x  = (c == ChLowX) || (c == ChUpX);
    item_cls.last  = in_ch.last;
  end

  // Two-entry queue toward the back end.
  assign in_ch.ready = (count_q != CntW'(Depth));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid_o   = (count_q != '0);
  assign q_item_o    = entries_q[rd_ptr_q];
  assign pop         = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= item_cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PtrW'(1);
      if (push && !pop) begin
        count_q <= count_q + CntW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

FILE: hdl/aip_back.sv
// Back end: runs the parse state machine on queued characters and
// finishes each string into the result register. Depends on aip_pkg and aip_result_if.
module aip_back #(
  parameter int unsigned MaxChars = 4096
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  aip_pkg::aip_item_t              q_item_i,
  output logic                            q_ready_o,
  input  logic [aip_pkg::RadixW-1:0]      radix_i,
  input  logic                            signed_mode_i,
  aip_result_if.source                    out_ch
);

  localparam int unsigned PosW = $clog2(MaxChars + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxChars);
  localparam int unsigned AccW = aip_pkg::AccW;
  localparam logic [aip_pkg::RadixW-1:0] RadixAuto = 6'd0;
  localparam logic [aip_pkg::RadixW-1:0] Radix8    = 6'd8;
  localparam logic [aip_pkg::RadixW-1:0] Radix10   = 6'd10;
  localparam logic [aip_pkg::RadixW-1:0] Radix16   = 6'd16;

  function automatic logic [PosW-1:0] sat_inc(input logic [PosW-1:0] v);
    return (v >= PosMax) ? PosMax : v + PosW'(1);
  endfunction

  aip_pkg::aip_phase_e          phase_q, phase_d;
  logic [AccW-1:0]              acc_q, acc_d, mac;
  logic                         neg_q, neg_d, any_q, any_d;
  logic [aip_pkg::RadixW-1:0]   base_q, base_d, base_begin, base_zero;
  logic [PosW-1:0]              pos_q, pos_d, dstart_q, dstart_d, stop_q, stop_d;
  logic                         begin_zero, begin_ok;

  aip_pkg::aip_raw_t            raw_q, raw_d;
  logic                         raw_valid_q, raw_ready, out_load;
  logic [PosW-1:0]              stop_f;
  logic                         step;

  logic                         out_valid_q;
  logic [AccW-1:0]              value_q, value_d;
  logic [aip_pkg::OffW-1:0]     off_q;
  logic                         conv_q, range_q, range_d;

  // Digit accumulation; the multiplier is 64 by 6 bits.
  assign mac = acc_q * AccW'(base_q) + AccW'(q_item_i.digit);

  // Base chosen at the start of the number and after a leading zero.
  assign base_begin = (radix_i == RadixAuto) ? Radix10 : radix_i;
  assign base_zero  = (radix_i == RadixAuto) ? Radix8 : Radix16;
  assign begin_zero = ((radix_i == RadixAuto) || (radix_i == Radix16)) &&
                      (q_item_i.digit == '0);
  assign begin_ok   = (q_item_i.digit < base_begin);

  // Next parse state for the character at the head of the queue.
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    any_d    = any_q;
    base_d   = base_q;
    dstart_d = dstart_q;
    stop_d   = stop_q;
    pos_d    = sat_inc(pos_q);
    unique case (phase_q)
      aip_pkg::PhSpace, aip_pkg::PhStart: begin
        if (phase_q == aip_pkg::PhSpace && q_item_i.blank) begin
          // Leading white space is skipped.
        end else if (phase_q == aip_pkg::PhSpace && q_item_i.sign) begin
          neg_d    = q_item_i.minus;
          dstart_d = sat_inc(pos_q);
          phase_d  = aip_pkg::PhStart;
        end else begin
          if (phase_q == aip_pkg::PhSpace) dstart_d = pos_q;
          if (begin_zero) begin
            phase_d = aip_pkg::PhZero;
          end else begin
            base_d = base_begin;
            if (begin_ok) begin
              acc_d   = AccW'(q_item_i.digit);
              any_d   = 1'b1;
              phase_d = aip_pkg::PhDigits;
            end else begin
              stop_d  = '0;
              phase_d = aip_pkg::PhDone;
            end
          end
        end
      end
      aip_pkg::PhZero: begin
        if (q_item_i.is_x) begin
          base_d  = Radix16;
          phase_d = aip_pkg::PhHexFirst;
        end else begin
          base_d = base_zero;
          any_d  = 1'b1;
          if (q_item_i.digit < base_zero) begin
            acc_d   = AccW'(q_item_i.digit);
            phase_d = aip_pkg::PhDigits;
          end else begin
            acc_d   = '0;
            stop_d  = pos_q;
            phase_d = aip_pkg::PhDone;
          end
        end
      end
      aip_pkg::PhHexFirst: begin
        if (q_item_i.digit < Radix16) begin
          acc_d   = AccW'(q_item_i.digit);
          any_d   = 1'b1;
          phase_d = aip_pkg::PhDigits;
        end else begin
          stop_d  = sat_inc(dstart_q);
          phase_d = aip_pkg::PhDone;
        end
      end
      aip_pkg::PhDigits: begin
        if (q_item_i.digit < base_q) begin
          acc_d = mac;
          any_d = 1'b1;
        end else begin
          stop_d  = any_q ? pos_q : '0;
          phase_d = aip_pkg::PhDone;
        end
      end
      aip_pkg::PhDone: begin
        // Characters after the stop are ignored.
      end
      default: begin
        phase_d = aip_pkg::PhSpace;
      end
    endcase
  end

  // End of string: the end acts like a NUL after the last character.
  always_comb begin
    raw_d          = '0;
    raw_d.acc      = acc_d;
    raw_d.negative = neg_d;
    raw_d.any_digit = any_d;
    unique case (phase_d)
      aip_pkg::PhZero: begin
        raw_d.acc       = '0;
        raw_d.any_digit = 1'b1;
        stop_f          = pos_d;
      end
      aip_pkg::PhHexFirst: stop_f = sat_inc(dstart_d);
      aip_pkg::PhDigits:   stop_f = any_d ? pos_d : '0;
      aip_pkg::PhDone:     stop_f = stop_d;
      default:             stop_f = '0;
    endcase
    raw_d.stop = aip_pkg::OffW'(stop_f);
  end

  // Handshakes between queue, raw result stage and output register.
  assign out_load  = raw_valid_q && (!out_valid_q || out_ch.ready);
  assign raw_ready = !raw_valid_q || out_load;
  assign q_ready_o = !q_item_i.last || raw_ready;
  assign step      = q_valid_i && q_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= aip_pkg::PhSpace;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      any_q    <= 1'b0;
      base_q   <= '0;
      pos_q    <= '0;
      dstart_q <= '0;
      stop_q   <= '0;
    end else if (step) begin
      if (q_item_i.last) begin
        phase_q  <= aip_pkg::PhSpace;
        acc_q    <= '0;
        neg_q    <= 1'b0;
        any_q    <= 1'b0;
        base_q   <= '0;
        pos_q    <= '0;
        dstart_q <= '0;
        stop_q   <= '0;
      end else begin
        phase_q  <= phase_d;
        acc_q    <= acc_d;
        neg_q    <= neg_d;
        any_q    <= any_d;
        base_q   <= base_d;
        pos_q    <= pos_d;
        dstart_q <= dstart_d;
        stop_q   <= stop_d;
      end
    end
  end

  // Raw result stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_valid_q <= 1'b0;
    end else if (step && q_item_i.last) begin
      raw_valid_q <= 1'b1;
    end else if (out_load) begin
      raw_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && q_item_i.last) begin
      raw_q <= raw_d;
    end
  end

  // Sign handling: saturate in signed mode, wrap otherwise.
  always_comb begin
    range_d = 1'b0;
    if (signed_mode_i) begin
      if (raw_q.negative) begin
        if (raw_q.acc > aip_pkg::LlongMin) begin
          value_d = aip_pkg::LlongMin;
          range_d = 1'b1;
        end else begin
          value_d = '0 - raw_q.acc;
        end
      end else if (raw_q.acc > aip_pkg::LlongMax) begin
        value_d = aip_pkg::LlongMax;
        range_d = 1'b1;
      end else begin
        value_d = raw_q.acc;
      end
    end else begin
      value_d = raw_q.negative ? ('0 - raw_q.acc) : raw_q.acc;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      value_q <= value_d;
      off_q   <= raw_q.stop;
      conv_q  <= raw_q.any_digit;
      range_q <= range_d;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.value       = value_q;
  assign out_ch.end_offset  = off_q;
  assign out_ch.converted   = conv_q;
  assign out_ch.range_error = range_q;

endmodule

FILE: hdl/aip_checker.sv
// Port-level checks of the integer parser and their bind to the top level.
// Depends on aip_pkg and ascii_integer_parser_macros.svh.
`include "ascii_integer_parser_macros.svh"

module aip_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [aip_pkg::AccW-1:0]  value_i,
  input logic [aip_pkg::OffW-1:0]  end_offset_i,
  input logic                      converted_i,
  input logic                      range_error_i
);

  // A stalled result holds until it is taken.
  `AIP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(value_i) && $stable(end_offset_i) && $stable(converted_i) && $stable(range_error_i), "result changed while stalled")

  // Nothing converted means a zero value and no range error.
  `AIP_ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, out_valid_i && !converted_i, value_i == '0 && !range_error_i, "unconverted result is not zero")

  // Saturation lands exactly on one of the signed limits.
  `AIP_ASSERT_IMPL(a_sat_limit, clk_i, rst_ni, out_valid_i && range_error_i, value_i == aip_pkg::LlongMin || value_i == aip_pkg::LlongMax, "saturated value is not a limit")

  // A range error needs converted digits.
  `AIP_ASSERT_IMPL(a_sat_conv, clk_i, rst_ni, out_valid_i && range_error_i, converted_i, "range error without digits")

endmodule

bind ascii_integer_parser aip_checker u_aip_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_ch.valid),
  .out_ready_i   (out_ch.ready),
  .value_i       (out_ch.value),
  .end_offset_i  (out_ch.end_offset),
  .converted_i   (out_ch.converted),
  .range_error_i (out_ch.range_error)
);

FILE: tb/ascii_integer_parser_tb.sv
// Self-checking testbench for the streaming ASCII integer parser.
// Needs aip_pkg, aip_char_if, aip_result_if and ascii_integer_parser; it
// predicts every parsed string and compares it with the result channel.
module ascii_integer_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxChars = 4096;
  localparam logic [5:0]  NotDigit = 6'd36;

  // One parsed string as it leaves the block.
  typedef struct packed {
    logic [aip_pkg::AccW-1:0] value;
    logic [aip_pkg::OffW-1:0] end_offset;
    logic                     converted;
    logic                     range_error;
  } parse_result_t;

  typedef logic [7:0] text_t[$];

  // Directed strings: '@' stands for NUL and '~' for byte 0xFF.
  typedef struct {
    logic [5:0]    radix;
    logic          sgn;
    string         text;
    bit            typed;
    parse_result_t want;
  } directed_row_t;

  directed_row_t directed_rows [8] = '{
    '{6'd0,  1'b0, "7",            1'b1, '{64'd7, 13'd1, 1'b1, 1'b0}},
    '{6'd0,  1'b0, "0x",           1'b1, '{64'd0, 13'd1, 1'b0, 1'b0}},
    '{6'd16, 1'b0, "0",            1'b1, '{64'd0, 13'd1, 1'b1, 1'b0}},
    '{6'd0,  1'b0, " -12",         1'b1, '{64'hFFFF_FFFF_FFFF_FFF4, 13'd4, 1'b1, 1'b0}},
    '{6'd0,  1'b0, "~",            1'b1, '{64'd0, 13'd0, 1'b0, 1'b0}},
    '{6'd0,  1'b1, "1@5",          1'b1, '{64'd1, 13'd1, 1'b1, 1'b0}},
    '{6'd1,  1'b0, "01",           1'b1, '{64'd0, 13'd1, 1'b1, 1'b0}},
    '{6'd63, 1'b1, "-9zzzzzzzzzz", 1'b0, '{64'd0, 13'd0, 1'b0, 1'b0}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                         cfg_we_i;
  logic [aip_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [aip_pkg::CfgDataW-1:0] cfg_data_i;

  aip_char_if   char_bus ();
  aip_result_if result_bus ();

  ascii_integer_parser #(.MaxChars(MaxChars)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (char_bus),
    .out_ch      (result_bus),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Register copies and parser state of the prediction.
  logic [5:0]               cfg_radix;
  logic                     cfg_signed;
  aip_pkg::aip_phase_e      ph;
  logic [aip_pkg::AccW-1:0] acc;
  logic                     neg;
  logic                     seen_digit;
  logic [5:0]               base;
  logic [aip_pkg::OffW-1:0] pos;
  logic [aip_pkg::OffW-1:0] num_start;
  logic [aip_pkg::OffW-1:0] stop_at;

  parse_result_t expected_results[$];
  int            error_count = 0;
  int            src_idle_pct;
  int            sink_idle_pct;

  function automatic logic [5:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 6'(c - "0");
    if (c >= "a" && c <= "z") return 6'(c - "a" + 8'd10);
    if (c >= "A" && c <= "Z") return 6'(c - "A" + 8'd10);
    return NotDigit;
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return 8'(d) + "0";
    return 8'(d - 10) + ($urandom_range(0, 1) ? "a" : "A");
  endfunction

  // Offsets stop counting at the maximum string length.
  function automatic logic [aip_pkg::OffW-1:0] bump(input logic [aip_pkg::OffW-1:0] v);
    return (v >= MaxChars) ? aip_pkg::OffW'(MaxChars) : v + 1'b1;
  endfunction

  function automatic void reset_parser();
    ph         = aip_pkg::PhSpace;
    acc        = '0;
    neg        = 1'b0;
    seen_digit = 1'b0;
    base       = '0;
    pos        = '0;
    num_start  = '0;
    stop_at    = '0;
  endfunction

  // Fold one digit into the accumulator, or stop at the first invalid one.
  function automatic void accumulate(input logic [7:0] c);
    logic [5:0] d;
    d = digit_value(c);
    if (d < base) begin
      acc        = acc * aip_pkg::AccW'(base) + aip_pkg::AccW'(d);
      seen_digit = 1'b1;
    end else begin
      stop_at = seen_digit ? pos : '0;
      ph      = aip_pkg::PhDone;
    end
  endfunction

  // A leading zero may still turn into a hex prefix in radix 0 or 16.
  function automatic void start_number(input logic [7:0] c);
    if ((cfg_radix == 6'd0 || cfg_radix == 6'd16) && c == "0") begin
      ph = aip_pkg::PhZero;
    end else begin
      base = (cfg_radix == 6'd0) ? 6'd10 : cfg_radix;
      ph   = aip_pkg::PhDigits;
      accumulate(c);
    end
  endfunction

  // Advance the predicted parser by one character; a last character
  // yields the expected result and clears the parse state.
  task automatic parse_char(input logic [7:0] c, input logic l, output bit emits,
                            output parse_result_t r);
    logic [5:0]               d;
    logic [aip_pkg::AccW-1:0] v;
    logic                     rng;
    emits = 1'b0;
    r     = '0;
    rng   = 1'b0;
    case (ph)
      aip_pkg::PhSpace: begin
        if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
          if (c == "+" || c == "-") begin
            neg       = (c == "-");
            num_start = bump(pos);
            ph        = aip_pkg::PhStart;
          end else begin
            num_start = pos;
            start_number(c);
          end
        end
      end
      aip_pkg::PhStart: start_number(c);
      aip_pkg::PhZero: begin
        if (c == "x" || c == "X") begin
          base = 6'd16;
          ph   = aip_pkg::PhHexFirst;
        end else begin
          base       = (cfg_radix == 6'd0) ? 6'd8 : 6'd16;
          acc        = '0;
          seen_digit = 1'b1;
          ph         = aip_pkg::PhDigits;
          accumulate(c);
        end
      end
      aip_pkg::PhHexFirst: begin
        d = digit_value(c);
        if (d < 6'd16) begin
          acc        = aip_pkg::AccW'(d);
          seen_digit = 1'b1;
          ph         = aip_pkg::PhDigits;
        end else begin
          stop_at = bump(num_start);
          ph      = aip_pkg::PhDone;
        end
      end
      aip_pkg::PhDigits: accumulate(c);
      default: ;
    endcase
    pos = bump(pos);
    if (!l) return;

    // The end of the string acts like a NUL after the last character.
    if (ph == aip_pkg::PhZero) begin
      acc        = '0;
      seen_digit = 1'b1;
      stop_at    = pos;
    end else if (ph == aip_pkg::PhHexFirst) begin
      stop_at = bump(num_start);
    end else if (ph == aip_pkg::PhDigits) begin
      stop_at = seen_digit ? pos : '0;
    end else if (ph != aip_pkg::PhDone) begin
      stop_at = '0;
    end

    // Signed mode saturates on the magnitude; unsigned mode wraps.
    if (cfg_signed && neg && acc > aip_pkg::LlongMin) begin
      v   = aip_pkg::LlongMin;
      rng = 1'b1;
    end else if (cfg_signed && !neg && acc > aip_pkg::LlongMax) begin
      v   = aip_pkg::LlongMax;
      rng = 1'b1;
    end else begin
      v = neg ? -acc : acc;
    end

    r.value       = v;
    r.end_offset  = stop_at;
    r.converted   = seen_digit;
    r.range_error = rng;
    emits         = 1'b1;
    reset_parser();
  endtask

  // Offer one character with random gaps and wait for its handshake.
  task automatic send_char(input logic [7:0] c, input logic l);
    bit            emits;
    parse_result_t r;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      char_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    char_bus.last      <= l;
    @(posedge clk_i);
    while (!char_bus.ready) @(posedge clk_i);
    parse_char(c, l, emits, r);
    if (emits) expected_results.push_back(r);
  endtask

  task automatic send_text(input text_t s);
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
  endtask

  // Drain every pending result, let the pipeline empty, then write both
  // registers on back-to-back edges.
  task automatic settle_then_configure(input logic [5:0] rdx, input logic sgn);
    char_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= aip_pkg::CfgRadix;
    cfg_data_i  <= rdx;
    @(posedge clk_i);
    cfg_index_i <= aip_pkg::CfgSigned;
    cfg_data_i  <= {5'b0, sgn};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_radix  = rdx;
    cfg_signed = sgn;
  endtask

  // Mostly well-formed numbers with random content; the rest is noise,
  // bare prefixes, lone signs and blanks.
  task automatic generate_string(output text_t s);
    int  n;
    int  gb;
    int  k;
    bit  top;
    s = {};
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 8);
      repeat (n) s.push_back(8'($urandom_range(0, 255)));
      return;
    end

    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        k = $urandom_range(8, 13);
        s.push_back((k == 8) ? " " : 8'(k));
      end
    end
    case ($urandom_range(0, 3))
      0: s.push_back("+");
      1: s.push_back("-");
      default: ;
    endcase

    gb = (cfg_radix == 6'd0) ? 10 : int'(cfg_radix);
    if ((cfg_radix == 6'd0 || cfg_radix == 6'd16) && $urandom_range(0, 2) == 0) begin
      s.push_back("0");
      s.push_back($urandom_range(0, 1) ? "x" : "X");
      gb = 16;
    end else if (cfg_radix == 6'd0 && $urandom_range(0, 3) == 0) begin
      s.push_back("0");
      gb = 8;
    end
    if (gb > 36) gb = 36;

    // Now and then sit right on the signed boundary in hex.
    if (gb == 16 && $urandom_range(0, 9) == 0) begin
      top = $urandom_range(0, 1);
      s.push_back(top ? "8" : "7");
      repeat (15) s.push_back(top ? "0" : "f");
    end else begin
      case ($urandom_range(0, 9))
        0:       n = 0;
        1, 2:    n = $urandom_range(7, 24);
        default: n = $urandom_range(1, 6);
      endcase
      repeat (n) s.push_back(digit_char($urandom_range(0, gb - 1)));
    end

    // How the number ends: string end, NUL, junk, or a digit out of range.
    case ($urandom_range(0, 3))
      1: begin
        s.push_back(8'h00);
        repeat ($urandom_range(0, 3)) s.push_back(8'($urandom_range(0, 255)));
      end
      2: repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(0, 255)));
      3: if (gb < 36) s.push_back(digit_char(gb));
      default: ;
    endcase
    if (s.size() == 0) s.push_back(" ");
  endtask

  // Result side stalls at random.
  initial begin
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      result_bus.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Compare each result with the oldest expected one.
  always @(posedge clk_i) begin
    parse_result_t want;
    if (rst_ni && result_bus.valid && result_bus.ready) begin
      if (expected_results.size() == 0) begin
        $error("result with no string pending: value %h", result_bus.value);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (result_bus.value !== want.value) begin
          $error("value: expected %h, got %h", want.value, result_bus.value);
          error_count++;
        end
        if (result_bus.end_offset !== want.end_offset) begin
          $error("end_offset: expected %0d, got %0d", want.end_offset,
                 result_bus.end_offset);
          error_count++;
        end
        if (result_bus.converted !== want.converted) begin
          $error("converted: expected %b, got %b", want.converted, result_bus.converted);
          error_count++;
        end
        if (result_bus.range_error !== want.range_error) begin
          $error("range_error: expected %b, got %b", want.range_error,
                 result_bus.range_error);
          error_count++;
        end
      end
    end
  end

  // Stimulus: directed strings, then three random phases.
  initial begin
    text_t      text;
    logic [7:0] c;
    logic [5:0] rdx;
    int         chars;
    int         strings;
    int         src_pct [3];
    int         sink_pct [3];
    src_pct  = '{24, 78, 0};
    sink_pct = '{78, 24, 0};

    rst_ni             <= 1'b0;
    char_bus.valid     <= 1'b0;
    char_bus.char_code <= '0;
    char_bus.last      <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_index_i        <= aip_pkg::CfgRadix;
    cfg_data_i         <= '0;
    cfg_radix     = '0;
    cfg_signed    = 1'b0;
    src_idle_pct  = src_pct[0];
    sink_idle_pct = sink_pct[0];
    reset_parser();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed strings; typed rows replace the predicted expectation.
    foreach (directed_rows[i]) begin
      settle_then_configure(directed_rows[i].radix, directed_rows[i].sgn);
      text = {};
      for (int j = 0; j < directed_rows[i].text.len(); j++) begin
        c = directed_rows[i].text[j];
        if (c == "@") c = 8'h00;
        else if (c == "~") c = 8'hFF;
        text.push_back(c);
      end
      send_text(text);
      if (directed_rows[i].typed) begin
        void'(expected_results.pop_back());
        expected_results.push_back(directed_rows[i].want);
      end
    end

    // Random strings, with new register settings every thirty strings.
    for (int p = 0; p < 3; p++) begin
      src_idle_pct  = src_pct[p];
      sink_idle_pct = sink_pct[p];
      chars   = 0;
      strings = 0;
      while (chars < 475) begin
        if (strings % 30 == 0) begin
          case ($urandom_range(0, 7))
            0:       rdx = 6'd0;
            1:       rdx = 6'd16;
            2:       rdx = 6'd10;
            3:       rdx = 6'd8;
            4:       rdx = 6'd36;
            5:       rdx = 6'd63;
            default: rdx = 6'($urandom_range(0, 63));
          endcase
          settle_then_configure(rdx, 1'($urandom_range(0, 1)));
        end
        generate_string(text);
        send_text(text);
        chars += text.size();
        strings++;
      end
    end

    char_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
